// File: rtl/i2c_bs_pkg.sv
// command codes, phase action type and phase decode for the i2c bit sequencer
// depends on nothing; imported by i2c_master_bit_sequencer and the testbench
package i2c_bs_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int PHASE_W       = 5;
    localparam int TICK_W        = 16;
    localparam logic [TICK_W-1:0] PHASE_TICKS_RESET = 16'd10;

    // command codes as they arrive on the input channel; idle marks no command
    typedef enum logic [2:0] {
        CMD_START = 3'd0,
        CMD_STOP  = 3'd1,
        CMD_WRITE = 3'd2,
        CMD_READ  = 3'd3,
        CMD_SACK  = 3'd4,
        CMD_RACK  = 3'd5,
        CMD_IDLE  = 3'd7
    } cmd_t;

    // what one pin phase does
    typedef struct packed {
        logic sda_we;
        logic sda_val;
        logic scl_we;
        logic scl_val;
        logic shift_in;
        logic ack_in;
    } phase_act_t;

    // number of phases in each command
    function automatic logic [PHASE_W-1:0] seq_len(cmd_t c);
        logic [PHASE_W-1:0] n;
        unique case (c)
            CMD_START: n = 5'd4;
            CMD_STOP:  n = 5'd3;
            CMD_WRITE: n = 5'(3 * BITS_PER_BYTE);
            CMD_READ:  n = 5'(1 + 3 * BITS_PER_BYTE);
            CMD_SACK:  n = 5'd3;
            CMD_RACK:  n = 5'd4;
            default:   n = 5'd0;
        endcase
        return n;
    endfunction

    // divide a phase index by three: times 11/32 is exact below 32
    function automatic logic [3:0] div3(logic [PHASE_W-1:0] p);
        logic [8:0] prod;
        prod = {4'b0, p} * 9'd11;
        return prod[8:5];
    endfunction

    function automatic logic [1:0] mod3(logic [PHASE_W-1:0] p);
        logic [PHASE_W-1:0] r;
        logic [3:0]         q;
        q = div3(p);
        r = p - 5'(3 * q);
        return r[1:0];
    endfunction

    // decode one phase of a command into pin actions
    function automatic phase_act_t phase_action(cmd_t c, logic [PHASE_W-1:0] p,
                                                logic [7:0] shift);
        phase_act_t a;
        logic [1:0] k;
        logic [3:0] q;
        logic [2:0] bit_idx;
        logic [PHASE_W-1:0] pm1;
        a       = '0;
        k       = mod3(p);
        q       = div3(p);
        bit_idx = 3'd7 - q[2:0];
        pm1     = p - 5'd1;
        unique case (c)
            CMD_START: begin
                unique case (p)
                    5'd0:    begin a.sda_we = 1'b1; a.sda_val = 1'b1; end
                    5'd1:    begin a.scl_we = 1'b1; a.scl_val = 1'b1; end
                    5'd2:    begin a.sda_we = 1'b1; a.sda_val = 1'b0; end
                    default: begin a.scl_we = 1'b1; a.scl_val = 1'b0; end
                endcase
            end
            CMD_STOP: begin
                unique case (p)
                    5'd0:    begin a.sda_we = 1'b1; a.sda_val = 1'b0; end
                    5'd1:    begin a.scl_we = 1'b1; a.scl_val = 1'b1; end
                    default: begin a.sda_we = 1'b1; a.sda_val = 1'b1; end
                endcase
            end
            CMD_WRITE: begin
                unique case (k)
                    2'd0:    begin a.sda_we = 1'b1; a.sda_val = shift[bit_idx]; end
                    2'd1:    begin a.scl_we = 1'b1; a.scl_val = 1'b1; end
                    default: begin a.scl_we = 1'b1; a.scl_val = 1'b0; end
                endcase
            end
            CMD_READ: begin
                if (p == 5'd0) begin
                    a.sda_we  = 1'b1;
                    a.sda_val = 1'b1;
                end else begin
                    unique case (mod3(pm1))
                        2'd0:    begin a.scl_we = 1'b1; a.scl_val = 1'b1; end
                        2'd1:    a.shift_in = 1'b1;
                        default: begin a.scl_we = 1'b1; a.scl_val = 1'b0; end
                    endcase
                end
            end
            CMD_SACK: begin
                unique case (p)
                    5'd0:    begin a.sda_we = 1'b1; a.sda_val = shift[0]; end
                    5'd1:    begin a.scl_we = 1'b1; a.scl_val = 1'b1; end
                    default: begin a.scl_we = 1'b1; a.scl_val = 1'b0; end
                endcase
            end
            CMD_RACK: begin
                unique case (p)
                    5'd0:    begin a.sda_we = 1'b1; a.sda_val = 1'b1; end
                    5'd1:    begin a.scl_we = 1'b1; a.scl_val = 1'b1; end
                    5'd2:    a.ack_in = 1'b1;
                    default: begin a.scl_we = 1'b1; a.scl_val = 1'b0; end
                endcase
            end
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// File: rtl/i2c_master_bit_sequencer.sv
// i2c master bit sequencer: plays start, stop, byte and ack commands as pin phases
// depends on i2c_bs_pkg for command codes and the phase decode
//
// Each input transfer is one bus tick and yields exactly one output transfer
// carrying the SCL and SDA levels after that tick, busy, a one-tick done flag,
// the last received byte and the last received ack bit. One transfer is taken
// every clock cycle: the tick is worked out in a single pass of logic from the
// sequencer state and the input transfer, and lands in the output register,
// so the input side stays ready while the output register is empty or being
// drained. Each pin phase is held for phase_ticks ticks (zero counts as one);
// a command offered while another runs, or with an unused code, is dropped.
// There is no clock stretching and no arbitration.
module i2c_master_bit_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // tx_byte[7:0], ack_out[8], sda_in[9], zeros
    input  logic [3:0]  s_tuser,   // cmd_valid[0], cmd[3:1]
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    // scl_level[0], sda_level[1], busy_res[2], done_res[3], rx_byte[11:4],
    // ack_received[12], zeros
    output logic [15:0] m_tdata,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import i2c_bs_pkg::*;

    // sequencer state
    logic [TICK_W-1:0]  phase_ticks_reg;
    cmd_t               active_reg,     active_next;
    logic [PHASE_W-1:0] phase_idx_reg,  phase_idx_next;
    logic [TICK_W-1:0]  tick_cnt_reg,   tick_cnt_next;
    logic [7:0]         shift_reg,      shift_next;
    logic               scl_reg,        scl_next;
    logic               sda_reg,        sda_next;
    logic               ack_reg,        ack_next;
    logic [7:0]         rx_hold_reg,    rx_hold_next;
    logic               done_next;
    logic               rx_load;

    // output register
    logic               m_tvalid_reg;
    logic [15:0]        m_tdata_reg;

    // input transfer fields
    logic               in_cmd_valid;
    logic [2:0]         in_cmd;
    logic [7:0]         in_tx_byte;
    logic               in_ack_out;
    logic               in_sda;
    logic               accept;

    assign in_cmd_valid = s_tuser[0];
    assign in_cmd       = s_tuser[3:1];
    assign in_tx_byte   = s_tdata[7:0];
    assign in_ack_out   = s_tdata[8];
    assign in_sda       = s_tdata[9];

    // take a new tick whenever the output register is free or draining
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // configuration: one register at byte address zero
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? {16'b0, phase_ticks_reg} : 32'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_ticks_reg <= PHASE_TICKS_RESET;
        end else if (cfg_wr) begin
            phase_ticks_reg <= pwdata[TICK_W-1:0];
        end
    end

    // one tick of the sequencer
    logic [TICK_W-1:0]  limit;
    logic [TICK_W-1:0]  tick_inc;
    logic [PHASE_W-1:0] phase_inc;
    logic               act_en;
    cmd_t               act_cmd;
    logic [PHASE_W-1:0] act_phase;
    logic [7:0]         act_shift;
    phase_act_t         act;

    assign limit     = (phase_ticks_reg == '0) ? TICK_W'(1) : phase_ticks_reg;
    assign tick_inc  = tick_cnt_reg + TICK_W'(1);
    assign phase_inc = phase_idx_reg + PHASE_W'(1);

    always_comb begin
        active_next    = active_reg;
        phase_idx_next = phase_idx_reg;
        tick_cnt_next  = tick_cnt_reg;
        rx_hold_next   = rx_hold_reg;
        done_next      = 1'b0;
        rx_load        = 1'b0;
        act_en         = 1'b0;
        act_cmd        = active_reg;
        act_phase      = phase_idx_reg;
        act_shift      = shift_reg;

        if (active_reg == CMD_IDLE) begin
            // start a new command; codes above receive ack are dropped
            if (in_cmd_valid && (in_cmd <= 3'(CMD_RACK))) begin
                active_next    = cmd_t'(in_cmd);
                phase_idx_next = '0;
                tick_cnt_next  = '0;
                act_en         = 1'b1;
                act_cmd        = cmd_t'(in_cmd);
                act_phase      = '0;
                case (cmd_t'(in_cmd))
                    CMD_WRITE: act_shift = in_tx_byte;
                    CMD_READ:  act_shift = 8'b0;
                    CMD_SACK:  act_shift = {7'b0, in_ack_out};
                    default:   act_shift = shift_reg;
                endcase
            end
        end else begin
            tick_cnt_next = tick_inc;
            // phase ends once its count reaches the hold time
            if (tick_inc >= limit) begin
                tick_cnt_next = '0;
                if (phase_inc >= seq_len(active_reg)) begin
                    if (active_reg == CMD_READ) begin
                        rx_hold_next = shift_reg;
                        rx_load      = accept;
                    end
                    active_next    = CMD_IDLE;
                    phase_idx_next = '0;
                    done_next      = 1'b1;
                end else begin
                    phase_idx_next = phase_inc;
                    act_en         = 1'b1;
                    act_phase      = phase_inc;
                end
            end
        end
    end

    assign act = phase_action(act_cmd, act_phase, act_shift);

    // apply the pin actions of the phase that acts this tick
    always_comb begin
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        ack_next   = ack_reg;
        shift_next = act_shift;
        if (act_en) begin
            if (act.sda_we)   sda_next   = act.sda_val;
            if (act.scl_we)   scl_next   = act.scl_val;
            if (act.shift_in) shift_next = {act_shift[6:0], in_sda};
            if (act.ack_in)   ack_next   = in_sda;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= CMD_IDLE;
            phase_idx_reg <= '0;
            tick_cnt_reg  <= '0;
            shift_reg     <= '0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            ack_reg       <= 1'b1;
            rx_hold_reg   <= '0;
        end else if (accept) begin
            active_reg    <= active_next;
            phase_idx_reg <= phase_idx_next;
            tick_cnt_reg  <= tick_cnt_next;
            shift_reg     <= shift_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
            ack_reg       <= ack_next;
            rx_hold_reg   <= rx_hold_next;
        end
    end

    // output register: valid is control, data is payload
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= {3'b0, ack_next, rx_hold_next, done_next,
                            (active_next != CMD_IDLE), sda_next, scl_next};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    // a running command never sits past the end of its phase list
    assert property (@(posedge aclk) disable iff (!aresetn)
        (active_reg != CMD_IDLE) |-> (phase_idx_reg < seq_len(active_reg)))
        else $error("phase index beyond command length");

    // idle sequencer holds cleared phase and tick counters
    assert property (@(posedge aclk) disable iff (!aresetn)
        (active_reg == CMD_IDLE) |-> (phase_idx_reg == '0 && tick_cnt_reg == '0))
        else $error("counters not cleared while idle");

    // received byte only changes when a read finishes
    assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(rx_hold_reg) |-> ($past(rx_load) || !$past(aresetn)))
        else $error("received byte changed outside a read completion");
`endif

endmodule

// File: dv/testbench.sv
// self-checking testbench for the i2c master bit sequencer
// depends on rtl/i2c_bs_pkg.sv and rtl/i2c_master_bit_sequencer.sv
`timescale 1ns / 1ps

module testbench;
    import i2c_bs_pkg::*;

    // register addresses; the spare one is not a register and must be ignored
    localparam logic [2:0] PHASE_TICKS_ADDR = 3'd0;
    localparam logic [2:0] SPARE_ADDR       = 3'd4;
    // command codes with no meaning, dropped by the block
    localparam logic [2:0] CODE_UNUSED_A    = 3'd6;
    localparam logic [2:0] CODE_UNUSED_B    = 3'd7;
    localparam int         CYCLE_LIMIT      = 5000000;
    localparam int         LONG_HOLD        = 400;

    // one bus tick as offered on the input channel
    typedef struct {
        logic       valid;
        logic [2:0] code;
        logic [7:0] txb;
        logic       acko;
        logic       sda;
    } tick_item_t;

    // pin and status levels after one tick
    typedef struct {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic [7:0] rx;
        logic       ack;
    } pin_state_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // tx_byte[7:0], ack_out[8], sda_in[9], zeros
    logic [3:0]  s_tuser  = '0;   // cmd_valid[0], cmd[3:1]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // scl_level[0], sda_level[1], busy_res[2], done_res[3], rx_byte[11:4],
    // ack_received[12], zeros
    logic [15:0] m_tdata;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    i2c_master_bit_sequencer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ticks waiting to be driven and pin states waiting to be seen
    tick_item_t pending_ticks[$];
    pin_state_t expected_pins[$];
    int         ticks_pushed = 0;
    int         ticks_taken  = 0;
    int         cmds_issued  = 0;
    int         err_count    = 0;
    int         cycle_cnt    = 0;
    logic       hold_arm     = 1'b0;

    // sequencer model state
    logic [15:0] cfg_phase_ticks = PHASE_TICKS_RESET;
    cmd_t        seq_cmd   = CMD_IDLE;
    logic [4:0]  seq_phase = '0;
    logic [15:0] seq_ticks = '0;
    logic [7:0]  seq_shift = '0;
    logic        scl_q     = 1'b1;
    logic        sda_q     = 1'b1;
    logic        ack_q     = 1'b1;
    logic [7:0]  rx_q      = '0;

    // number of pin phases a command runs through
    function automatic int phase_count(cmd_t c);
        case (c)
            CMD_START: return 4;
            CMD_STOP:  return 3;
            CMD_WRITE: return 3 * BITS_PER_BYTE;
            CMD_READ:  return 1 + 3 * BITS_PER_BYTE;
            CMD_SACK:  return 3;
            CMD_RACK:  return 4;
            default:   return 0;
        endcase
    endfunction

    // carry out one pin phase of the running command
    task automatic play_phase(input cmd_t c, input int p, input logic sda);
        int k;
        int q;
        case (c)
            CMD_START: begin
                if (p == 0) sda_q = 1'b1;
                else if (p == 1) scl_q = 1'b1;
                else if (p == 2) sda_q = 1'b0;
                else scl_q = 1'b0;
            end
            CMD_STOP: begin
                if (p == 0) sda_q = 1'b0;
                else if (p == 1) scl_q = 1'b1;
                else sda_q = 1'b1;
            end
            CMD_WRITE: begin
                // bit, clock high, clock low; msb goes out first
                k = p % 3;
                q = (p / 3) & 7;
                if (k == 0) sda_q = seq_shift[7 - q];
                else if (k == 1) scl_q = 1'b1;
                else scl_q = 1'b0;
            end
            CMD_READ: begin
                // release sda once, then clock high, sample, clock low per bit
                if (p == 0) begin
                    sda_q = 1'b1;
                end else begin
                    k = (p - 1) % 3;
                    if (k == 0) scl_q = 1'b1;
                    else if (k == 1) seq_shift = {seq_shift[6:0], sda};
                    else scl_q = 1'b0;
                end
            end
            CMD_SACK: begin
                if (p == 0) sda_q = seq_shift[0];
                else if (p == 1) scl_q = 1'b1;
                else scl_q = 1'b0;
            end
            CMD_RACK: begin
                if (p == 0) sda_q = 1'b1;
                else if (p == 1) scl_q = 1'b1;
                else if (p == 2) ack_q = sda;
                else scl_q = 1'b0;
            end
            default: ;
        endcase
    endtask

    // advance the sequencer model by one tick and give its pin state
    task automatic sequencer_tick(input tick_item_t it, output pin_state_t r);
        logic [15:0] limit;
        logic        done;
        limit = (cfg_phase_ticks == 16'd0) ? 16'd1 : cfg_phase_ticks;
        done  = 1'b0;
        if (seq_cmd == CMD_IDLE) begin
            // only a valid, known command starts; phase 0 acts at once
            if (it.valid && it.code <= CMD_RACK) begin
                seq_cmd   = cmd_t'(it.code);
                seq_phase = '0;
                seq_ticks = '0;
                if (seq_cmd == CMD_WRITE) seq_shift = it.txb;
                else if (seq_cmd == CMD_READ) seq_shift = '0;
                else if (seq_cmd == CMD_SACK) seq_shift = {7'd0, it.acko};
                play_phase(seq_cmd, 0, it.sda);
            end
        end else begin
            // busy: commands are dropped, the phase timer runs
            seq_ticks = seq_ticks + 16'd1;
            if (seq_ticks >= limit) begin
                seq_ticks = '0;
                seq_phase = seq_phase + 5'd1;
                if (int'(seq_phase) >= phase_count(seq_cmd)) begin
                    if (seq_cmd == CMD_READ) rx_q = seq_shift;
                    seq_cmd   = CMD_IDLE;
                    seq_phase = '0;
                    done      = 1'b1;
                end else begin
                    play_phase(seq_cmd, int'(seq_phase), it.sda);
                end
            end
        end
        r.scl  = scl_q;
        r.sda  = sda_q;
        r.busy = (seq_cmd != CMD_IDLE);
        r.done = done;
        r.rx   = rx_q;
        r.ack  = ack_q;
    endtask

    // idle length for either side: mostly none or short, a few long,
    // and now and then a calm stretch with none at all
    function automatic int pick_idle(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            calm = $urandom_range(50, 300);
            return 0;
        end
        if (r < 75) return 0;
        if (r < 96) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic pick_sda(int sda_fix);
        if (sda_fix < 0) return 1'($urandom_range(0, 1));
        return sda_fix[0];
    endfunction

    task automatic push_tick(input logic valid, input logic [2:0] code,
                             input logic [7:0] txb, input logic acko, input logic sda);
        tick_item_t t;
        t.valid = valid;
        t.code  = code;
        t.txb   = txb;
        t.acko  = acko;
        t.sda   = sda;
        pending_ticks.push_back(t);
        ticks_pushed++;
    endtask

    // one command followed by the ticks it keeps the block busy; busy ticks
    // may carry commands that must be dropped, the done tick more often
    task automatic emit_cmd(input logic [2:0] code, input logic [7:0] txb,
                            input logic acko, input int sda_fix, input int busy_noise);
        int eff;
        int span;
        int pct;
        eff  = (cfg_phase_ticks == 16'd0) ? 1 : int'(cfg_phase_ticks);
        span = (code <= CMD_RACK) ? phase_count(cmd_t'(code)) * eff : 0;
        push_tick(1'b1, code, txb, acko, pick_sda(sda_fix));
        for (int i = 1; i <= span; i++) begin
            pct = (i == span && busy_noise < 20) ? 20 : busy_noise;
            push_tick(1'($urandom_range(0, 99) < pct), 3'($urandom_range(0, 7)),
                      8'($urandom), 1'($urandom), pick_sda(sda_fix));
        end
        repeat ($urandom_range(0, 2))
            push_tick(1'b0, 3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
                      pick_sda(sda_fix));
        cmds_issued++;
    endtask

    // start, address, ack, one to three data bytes, each written or read, stop
    task automatic emit_transaction();
        int n;
        emit_cmd(CMD_START, 8'($urandom), 1'($urandom), -1, 3);
        emit_cmd(CMD_WRITE, 8'($urandom), 1'($urandom), -1, 3);
        emit_cmd(CMD_RACK, 8'($urandom), 1'($urandom), -1, 3);
        n = $urandom_range(1, 3);
        repeat (n) begin
            if ($urandom_range(0, 1)) begin
                emit_cmd(CMD_WRITE, 8'($urandom), 1'($urandom), -1, 3);
                emit_cmd(CMD_RACK, 8'($urandom), 1'($urandom), -1, 3);
            end else begin
                emit_cmd(CMD_READ, 8'($urandom), 1'($urandom), -1, 3);
                emit_cmd(CMD_SACK, 8'($urandom), 1'($urandom), -1, 3);
            end
        end
        emit_cmd(CMD_STOP, 8'($urandom), 1'($urandom), -1, 3);
    endtask

    // hold the sender until every tick is taken and every pin state seen,
    // then pad with idle ticks until no command runs
    task automatic wait_drained();
        while (!(ticks_taken == ticks_pushed && expected_pins.size() == 0))
            @(posedge aclk);
        while (seq_cmd != CMD_IDLE) begin
            push_tick(1'b0, CMD_START, 8'd0, 1'b0, 1'($urandom));
            while (!(ticks_taken == ticks_pushed && expected_pins.size() == 0))
                @(posedge aclk);
        end
    endtask

    // setup cycle, access cycle; the register takes the value at the access edge
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        wait_drained();
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == PHASE_TICKS_ADDR) cfg_phase_ticks = data[15:0];
    endtask

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name,
                     exp_v, act_v);
            err_count++;
        end
    endtask

    // driver: offer queued ticks, predict each one at its transfer
    tick_item_t cur_item;
    int         tx_gap  = 0;
    int         tx_calm = 0;

    always @(posedge aclk) begin : drive_proc
        logic       next_valid;
        pin_state_t predicted;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                sequencer_tick(cur_item, predicted);
                expected_pins.push_back(predicted);
                ticks_taken++;
            end
            if (s_tvalid && !s_tready) begin
                // stalled: keep the same tick on the bus
                next_valid = 1'b1;
            end else if (tx_gap > 0) begin
                tx_gap--;
                next_valid = 1'b0;
            end else if (pending_ticks.size() > 0) begin
                cur_item = pending_ticks.pop_front();
                s_tdata  <= {6'd0, cur_item.sda, cur_item.acko, cur_item.txb};
                s_tuser  <= {cur_item.code, cur_item.valid};
                next_valid = 1'b1;
                tx_gap = pick_idle(tx_calm);
            end else begin
                next_valid = 1'b0;
            end
            s_tvalid <= next_valid;
        end
    end

    // monitor: check each pin state transfer, throttle with random stalls
    // and one long hold that backs the block up into its input
    int   rx_stall  = 0;
    int   rx_calm   = 0;
    int   hold_left = 0;
    logic hold_done = 1'b0;

    always @(posedge aclk) begin : receive_proc
        logic       rdy;
        pin_state_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_pins.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %04h", $time,
                         m_tdata);
                err_count++;
            end else begin
                want = expected_pins.pop_front();
                check_field("scl_level", want.scl, m_tdata[0]);
                check_field("sda_level", want.sda, m_tdata[1]);
                check_field("busy_res", want.busy, m_tdata[2]);
                check_field("done_res", want.done, m_tdata[3]);
                check_field("rx_byte", want.rx, m_tdata[11:4]);
                check_field("ack_received", want.ack, m_tdata[12]);
            end
        end
        if (hold_arm && !hold_done) begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall--;
            rdy = 1'b0;
        end else begin
            rdy = 1'b1;
            rx_stall = pick_idle(rx_calm);
        end
        m_tready <= rdy;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    int unsigned rand_settings[4] = '{2, 1, 0, 3};

    initial begin : stimulus
        int r;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // reset phase length: framing and ack commands, forced samples
        emit_cmd(CMD_START, 8'h00, 1'b0, -1, 3);
        emit_cmd(CMD_RACK, 8'h00, 1'b0, 0, 3);
        emit_cmd(CMD_STOP, 8'h00, 1'b0, -1, 3);
        // unused codes and an unflagged command while idle are dropped
        emit_cmd(CODE_UNUSED_A, 8'hFF, 1'b1, -1, 3);
        emit_cmd(CODE_UNUSED_B, 8'hFF, 1'b1, -1, 3);
        push_tick(1'b0, CMD_START, 8'h00, 1'b0, 1'b1);
        // a command on every busy tick, the done tick included, is dropped
        emit_cmd(CMD_SACK, 8'h00, 1'b1, -1, 100);

        // one tick per phase: byte extremes and forced samples both ways
        apb_write(PHASE_TICKS_ADDR, 32'd1);
        emit_cmd(CMD_WRITE, 8'hA5, 1'b0, -1, 3);
        emit_cmd(CMD_RACK, 8'h00, 1'b0, 0, 3);
        emit_cmd(CMD_WRITE, 8'h5A, 1'b1, -1, 3);
        emit_cmd(CMD_RACK, 8'h00, 1'b0, 1, 3);
        emit_cmd(CMD_READ, 8'h00, 1'b0, 1, 3);
        emit_cmd(CMD_SACK, 8'hFF, 1'b0, -1, 3);
        emit_cmd(CMD_READ, 8'hFF, 1'b1, 0, 3);
        emit_cmd(CMD_SACK, 8'h00, 1'b1, -1, 3);

        // zero phase length behaves as one
        apb_write(PHASE_TICKS_ADDR, 32'd0);
        emit_cmd(CMD_WRITE, 8'hFF, 1'b0, -1, 3);
        emit_cmd(CMD_WRITE, 8'h00, 1'b1, -1, 3);
        emit_cmd(CMD_READ, 8'h00, 1'b0, 1, 3);
        emit_cmd(CMD_READ, 8'h00, 1'b0, 0, 3);
        emit_cmd(CMD_RACK, 8'h00, 1'b0, 0, 3);

        // write to an address with no register leaves the length alone
        apb_write(SPARE_ADDR, 32'd3);
        emit_cmd(CMD_START, 8'h00, 1'b0, -1, 3);
        emit_cmd(CMD_STOP, 8'h00, 1'b0, -1, 3);

        // only the low 16 bits of the write count
        apb_write(PHASE_TICKS_ADDR, 32'hFFFF_0001);
        emit_cmd(CMD_SACK, 8'h00, 1'b0, -1, 3);

        // random part: mostly well-formed transactions, some stray commands
        foreach (rand_settings[i]) begin
            apb_write(PHASE_TICKS_ADDR, rand_settings[i]);
            if (i == 1) hold_arm = 1'b1;
            cmds_issued = 0;
            while (cmds_issued < 5) begin
                r = $urandom_range(0, 99);
                if (r < 80) begin
                    emit_transaction();
                end else if (r < 92) begin
                    emit_cmd(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom), -1, 5);
                end else begin
                    push_tick(1'b0, 3'($urandom_range(0, 7)), 8'($urandom),
                              1'($urandom), 1'($urandom));
                end
            end
        end

        wait_drained();
        // the block answers one tick per transfer; a final wait catches stray results
        repeat (10) @(posedge aclk);
        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: i2c_master_bit_sequencer.f
rtl/i2c_bs_pkg.sv
rtl/i2c_master_bit_sequencer.sv
dv/testbench.sv
